@@ design/msp_pkg.sv @@
// Shared types, codes and Q8.8 saturating arithmetic for the motor speed controller.
package msp_pkg;

    // Signed Q8.8 value.
    typedef logic signed [15:0] q_t;

    localparam q_t Q_MIN = 16'sh8000;
    localparam q_t Q_MAX = 16'sh7FFF;

    // Power after reset or a clear, -128.0.
    localparam q_t POWER_CLEAR = Q_MIN;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic
    {
        OPC_UPDATE = 1'b0,
        OPC_CLEAR  = 1'b1
    } msp_opcode_t;

    typedef enum logic [2:0]
    {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_STEP_TIME = 3'd3,
        REG_STEP_RATE = 3'd4
    } msp_reg_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PREP,
        ST_START,
        ST_WAIT,
        ST_DONE
    } msp_state_t;

    // The five products, in the order the sequencer runs them.
    typedef enum logic [2:0]
    {
        OP_INTEG,
        OP_DERIV,
        OP_PROP,
        OP_ISUM,
        OP_DSUM
    } msp_mul_op_t;

    function automatic q_t sat17(input logic signed [16:0] v);
        q_t r;
        if (v[16] != v[15])
        begin
            r = v[16] ? Q_MIN : Q_MAX;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic q_t qadd(input q_t a, input q_t b);
        logic signed [16:0] s;
        s = {a[15], a} + {b[15], b};
        return sat17(s);
    endfunction

    function automatic q_t qsub(input q_t a, input q_t b);
        logic signed [16:0] s;
        s = {a[15], a} - {b[15], b};
        return sat17(s);
    endfunction

    // Saturates a product already shifted right by eight bits.
    function automatic q_t sat25(input logic signed [24:0] v);
        q_t r;
        if (v[24:15] == 10'h000 || v[24:15] == 10'h3FF)
        begin
            r = v[15:0];
        end
        else
        begin
            r = v[24] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

endpackage

@@ design/msp_cmd_if.sv @@
// Handshake channel that carries one controller command word.
interface msp_cmd_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] target_speed;
    logic [7:0] measured_speed;

    modport source (output valid, output opcode, output target_speed,
                    output measured_speed, input ready);
    modport sink (input valid, input opcode, input target_speed,
                  input measured_speed, output ready);
endinterface

@@ design/msp_res_if.sv @@
// Handshake channel that carries one drive power word.
interface msp_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] drive_power;

    modport source (output valid, output drive_power, input ready);
    modport sink (input valid, input drive_power, output ready);
endinterface

@@ design/msp_mul.sv @@
// Bit-serial signed 16 x 16 multiplier giving a saturated Q8.8 product.
module msp_mul
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  msp_pkg::q_t   a,
    input  msp_pkg::q_t   b,
    output logic          done,
    output msp_pkg::q_t   q
);

    logic               run_reg,    run_next;
    logic               done_reg,   done_next;
    logic [3:0]         cnt_reg,    cnt_next;
    msp_pkg::q_t        mcand_reg,  mcand_next;
    logic [15:0]        mplier_reg, mplier_next;
    logic signed [16:0] acc_reg,    acc_next;
    logic [15:0]        lo_reg,     lo_next;

    logic signed [17:0] addend;
    logic signed [17:0] sum;
    logic signed [24:0] shifted;

    always_comb
    begin
        run_next    = run_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        lo_next     = lo_reg;

        // The top multiplier bit has negative weight, so it subtracts.
        if (!mplier_reg[0])
        begin
            addend = '0;
        end
        else if (cnt_reg == 4'd15)
        begin
            addend = -{{2{mcand_reg[15]}}, mcand_reg};
        end
        else
        begin
            addend = {{2{mcand_reg[15]}}, mcand_reg};
        end
        sum = {acc_reg[16], acc_reg} + addend;

        if (start)
        begin
            run_next    = 1'b1;
            cnt_next    = '0;
            mcand_next  = a;
            mplier_next = b;
            acc_next    = '0;
            lo_next     = '0;
        end
        else if (run_reg)
        begin
            acc_next    = sum[17:1];
            lo_next     = {sum[0], lo_reg[15:1]};
            mplier_next = {1'b0, mplier_reg[15:1]};
            cnt_next    = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        lo_reg     <= lo_next;
    end

    // Dropping the low byte of the 32-bit product is the floor shift by eight.
    assign shifted = {acc_reg, lo_reg[15:8]};
    assign q       = msp_pkg::sat25(shifted);
    assign done    = done_reg;

endmodule

@@ design/motor_speed_pid.sv @@
// Velocity-form PID motor speed controller in Q8.8 fixed point.
//
// Each command word carries a target and a measured speed; an update word
// adds Kp*e + Ki*I + Kd*(e - pe)*rate to the accumulated power and answers
// the integer part of the power plus 128, while a clear word resets the
// integral, previous error and power (-128.0) and answers 0. Every product
// and sum saturates at the Q8.8 limits. The five products run one after
// another through a single bit-serial multiplier, and one command is in
// flight at a time. A finished result waits in an output register, and the
// next command is taken meanwhile. Gains and step values are written through
// the APB port at byte addresses 0, 4, 8, 12 and 16; the user must write
// them only while the block is idle, as the block itself does not enforce it.
module motor_speed_pid
(
    input  logic                           clk,
    input  logic                           rst_n,
    msp_cmd_if.sink                        cmd,
    msp_res_if.source                      result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [msp_pkg::PADDR_W-1:0]    paddr,
    input  logic [msp_pkg::PDATA_W-1:0]    pwdata,
    output logic [msp_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    // Configuration registers.
    msp_pkg::q_t  gain_p_reg;
    msp_pkg::q_t  gain_i_reg;
    msp_pkg::q_t  gain_d_reg;
    logic [14:0]  step_time_reg;
    logic [14:0]  step_rate_reg;

    msp_pkg::msp_reg_t reg_sel;
    logic              cfg_write;

    // Controller state and sequencing.
    msp_pkg::msp_state_t  state_reg,     state_next;
    msp_pkg::msp_mul_op_t op_reg,        op_next;
    msp_pkg::q_t          error_sum_reg, error_sum_next;
    msp_pkg::q_t          last_error_reg, last_error_next;
    msp_pkg::q_t          power_reg,     power_next;
    msp_pkg::q_t          err_reg,       err_next;
    msp_pkg::q_t          dterm_reg,     dterm_next;
    msp_pkg::q_t          u_reg,         u_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_data_reg,  out_data_next;

    logic                 mul_start;
    logic                 mul_done;
    msp_pkg::q_t          mul_a;
    msp_pkg::q_t          mul_b;
    msp_pkg::q_t          mul_q;

    logic signed [8:0]    diff;
    logic signed [7:0]    diff_clamped;
    msp_pkg::q_t          power_sum;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_sel   = msp_pkg::msp_reg_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= 16'sd256;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            step_time_reg <= 15'd26;
            step_rate_reg <= 15'd2560;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                msp_pkg::REG_GAIN_P:    gain_p_reg    <= pwdata[15:0];
                msp_pkg::REG_GAIN_I:    gain_i_reg    <= pwdata[15:0];
                msp_pkg::REG_GAIN_D:    gain_d_reg    <= pwdata[15:0];
                msp_pkg::REG_STEP_TIME: step_time_reg <= pwdata[14:0];
                msp_pkg::REG_STEP_RATE: step_rate_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            msp_pkg::REG_GAIN_P:    prdata = {16'h0000, gain_p_reg};
            msp_pkg::REG_GAIN_I:    prdata = {16'h0000, gain_i_reg};
            msp_pkg::REG_GAIN_D:    prdata = {16'h0000, gain_d_reg};
            msp_pkg::REG_STEP_TIME: prdata = {17'h00000, step_time_reg};
            msp_pkg::REG_STEP_RATE: prdata = {17'h00000, step_rate_reg};
            default:                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Shared multiplier
    // ---------------------------------------------------------------
    always_comb
    begin
        unique case (op_reg)
            msp_pkg::OP_INTEG:
            begin
                mul_a = err_reg;
                mul_b = {1'b0, step_time_reg};
            end
            msp_pkg::OP_DERIV:
            begin
                mul_a = dterm_reg;
                mul_b = {1'b0, step_rate_reg};
            end
            msp_pkg::OP_PROP:
            begin
                mul_a = gain_p_reg;
                mul_b = err_reg;
            end
            msp_pkg::OP_ISUM:
            begin
                mul_a = gain_i_reg;
                mul_b = error_sum_reg;
            end
            msp_pkg::OP_DSUM:
            begin
                mul_a = gain_d_reg;
                mul_b = dterm_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    msp_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .q     (mul_q)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign diff = $signed({1'b0, cmd.target_speed}) - $signed({1'b0, cmd.measured_speed});

    always_comb
    begin
        if (diff < -9'sd128)
        begin
            diff_clamped = -8'sd128;
        end
        else if (diff > 9'sd127)
        begin
            diff_clamped = 8'sd127;
        end
        else
        begin
            diff_clamped = diff[7:0];
        end
    end

    assign power_sum = msp_pkg::qadd(power_reg, u_reg);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        error_sum_next  = error_sum_reg;
        last_error_next = last_error_reg;
        power_next      = power_reg;
        err_next        = err_reg;
        dterm_next      = dterm_reg;
        u_next          = u_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        mul_start       = 1'b0;
        cmd.ready       = 1'b0;

        unique case (state_reg)
            msp_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    if (cmd.opcode == msp_pkg::OPC_CLEAR)
                    begin
                        // Power stays at -128.0, so the answer byte is zero.
                        error_sum_next  = '0;
                        last_error_next = '0;
                        power_next      = msp_pkg::POWER_CLEAR;
                        u_next          = '0;
                        state_next      = msp_pkg::ST_DONE;
                    end
                    else
                    begin
                        err_next   = {diff_clamped, 8'h00};
                        state_next = msp_pkg::ST_PREP;
                    end
                end
            end

            msp_pkg::ST_PREP:
            begin
                dterm_next      = msp_pkg::qsub(err_reg, last_error_reg);
                last_error_next = err_reg;
                op_next         = msp_pkg::OP_INTEG;
                state_next      = msp_pkg::ST_START;
            end

            msp_pkg::ST_START:
            begin
                mul_start  = 1'b1;
                state_next = msp_pkg::ST_WAIT;
            end

            msp_pkg::ST_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = msp_pkg::ST_START;
                    unique case (op_reg)
                        msp_pkg::OP_INTEG:
                        begin
                            error_sum_next = msp_pkg::qadd(error_sum_reg, mul_q);
                            op_next        = msp_pkg::OP_DERIV;
                        end
                        msp_pkg::OP_DERIV:
                        begin
                            // The difference is no longer needed once scaled.
                            dterm_next = mul_q;
                            op_next    = msp_pkg::OP_PROP;
                        end
                        msp_pkg::OP_PROP:
                        begin
                            u_next  = mul_q;
                            op_next = msp_pkg::OP_ISUM;
                        end
                        msp_pkg::OP_ISUM:
                        begin
                            u_next  = msp_pkg::qadd(u_reg, mul_q);
                            op_next = msp_pkg::OP_DSUM;
                        end
                        msp_pkg::OP_DSUM:
                        begin
                            u_next     = msp_pkg::qadd(u_reg, mul_q);
                            state_next = msp_pkg::ST_DONE;
                        end
                        default:
                        begin
                            state_next = msp_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            msp_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    power_next     = power_sum;
                    out_data_next  = power_sum[15:8] ^ 8'h80;
                    out_valid_next = 1'b1;
                    state_next     = msp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = msp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= msp_pkg::ST_IDLE;
            op_reg         <= msp_pkg::OP_INTEG;
            out_valid_reg  <= 1'b0;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            power_reg      <= msp_pkg::POWER_CLEAR;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            out_valid_reg  <= out_valid_next;
            error_sum_reg  <= error_sum_next;
            last_error_reg <= last_error_next;
            power_reg      <= power_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg      <= err_next;
        dterm_reg    <= dterm_next;
        u_reg        <= u_next;
        out_data_reg <= out_data_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.drive_power = out_data_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the Q8.8 PID motor speed controller.
module testbench;

    localparam int QUIET_LIMIT   = 3000;
    localparam int RANDOM_WORDS  = 650;
    localparam int PHASES        = 10;
    localparam int SETTLE_CYCLES = 120;
    localparam int DIRECTED_ROWS = 18;

    typedef logic [msp_pkg::PADDR_W-1:0] paddr_t;

    typedef struct packed
    {
        msp_pkg::msp_opcode_t op;
        logic [7:0]           tgt;
        logic [7:0]           meas;
        logic                 fixed;
        logic [7:0]           want;
    } cmd_row_t;

    typedef struct packed
    {
        msp_pkg::q_t kp;
        msp_pkg::q_t ki;
        msp_pkg::q_t kd;
        logic [14:0] dt;
        logic [14:0] rate;
    } gain_set_t;

    // Rows marked fixed carry a result that is obvious from the state; the rest
    // are checked against the controller model below.
    localparam cmd_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{msp_pkg::OPC_CLEAR,  8'd255, 8'd255, 1'b1, 8'd0},
        '{msp_pkg::OPC_UPDATE, 8'd0,   8'd0,   1'b1, 8'd0},
        '{msp_pkg::OPC_UPDATE, 8'd255, 8'd0,   1'b0, 8'd0},
        '{msp_pkg::OPC_UPDATE, 8'd255, 8'd0,   1'b0, 8'd0},
        '{msp_pkg::OPC_UPDATE, 8'd255, 8'd0,   1'b1, 8'd255},
        '{msp_pkg::OPC_UPDATE, 8'd0,   8'd255, 1'b0, 8'd0},
        '{msp_pkg::OPC_UPDATE, 8'd0,   8'd128, 1'b0, 8'd0},
        '{msp_pkg::OPC_UPDATE, 8'd0,   8'd129, 1'b1, 8'd0},
        '{msp_pkg::OPC_UPDATE, 8'd127, 8'd0,   1'b0, 8'd0},
        '{msp_pkg::OPC_UPDATE, 8'd128, 8'd1,   1'b0, 8'd0},
        '{msp_pkg::OPC_CLEAR,  8'd0,   8'd0,   1'b1, 8'd0},
        '{msp_pkg::OPC_UPDATE, 8'd1,   8'd0,   1'b0, 8'd0},
        '{msp_pkg::OPC_UPDATE, 8'd0,   8'd1,   1'b0, 8'd0},
        '{msp_pkg::OPC_UPDATE, 8'd200, 8'd100, 1'b0, 8'd0},
        '{msp_pkg::OPC_UPDATE, 8'd100, 8'd200, 1'b0, 8'd0},
        '{msp_pkg::OPC_CLEAR,  8'd170, 8'd85,  1'b1, 8'd0},
        '{msp_pkg::OPC_UPDATE, 8'd85,  8'd170, 1'b0, 8'd0},
        '{msp_pkg::OPC_UPDATE, 8'd170, 8'd85,  1'b0, 8'd0}
    };

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [msp_pkg::PADDR_W-1:0] paddr;
    logic [msp_pkg::PDATA_W-1:0] pwdata;
    logic [msp_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    msp_cmd_if cmd();
    msp_res_if result();

    motor_speed_pid dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Controller model state and its copy of the gain registers.
    gain_set_t   gains;
    msp_pkg::q_t integ;
    msp_pkg::q_t prev_err;
    msp_pkg::q_t power;
    logic [7:0]  power_due[$];
    logic [7:0]  due_power;

    int errors;
    int quiet;
    int send_idle_pct;
    int recv_idle_pct;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic msp_pkg::q_t q_clip(input longint v);
        if (v < longint'(msp_pkg::Q_MIN))
        begin
            return msp_pkg::Q_MIN;
        end
        if (v > longint'(msp_pkg::Q_MAX))
        begin
            return msp_pkg::Q_MAX;
        end
        return msp_pkg::q_t'(v[15:0]);
    endfunction

    // Exact product, floored by the arithmetic shift, then saturated.
    function automatic msp_pkg::q_t q_mul(input longint a, input longint b);
        return q_clip((a * b) >>> 8);
    endfunction

    function automatic void reset_model();
        gains.kp   = 16'sd256;
        gains.ki   = 16'sd0;
        gains.kd   = 16'sd0;
        gains.dt   = 15'd26;
        gains.rate = 15'd2560;
        integ      = '0;
        prev_err   = '0;
        power      = msp_pkg::POWER_CLEAR;
    endfunction

    // Advances the model by one command word and gives the drive power byte.
    function automatic logic [7:0] next_power(input cmd_row_t w);
        int diff;
        msp_pkg::q_t err;
        msp_pkg::q_t deriv;
        msp_pkg::q_t u;
        if (w.op == msp_pkg::OPC_CLEAR)
        begin
            integ    = '0;
            prev_err = '0;
            power    = msp_pkg::POWER_CLEAR;
            return 8'd0;
        end
        diff = int'(w.tgt) - int'(w.meas);
        if (diff < -128)
        begin
            diff = -128;
        end
        if (diff > 127)
        begin
            diff = 127;
        end
        err      = msp_pkg::q_t'(diff * 256);
        integ    = q_clip(longint'(integ) + longint'(q_mul(err, gains.dt)));
        deriv    = q_mul(q_clip(longint'(err) - longint'(prev_err)), gains.rate);
        prev_err = err;
        u        = q_mul(gains.kp, err);
        u        = q_clip(longint'(u) + longint'(q_mul(gains.ki, integ)));
        u        = q_clip(longint'(u) + longint'(q_mul(gains.kd, deriv)));
        power    = q_clip(longint'(power) + longint'(u));
        return power[15:8] + 8'd128;
    endfunction

    function automatic paddr_t reg_addr(input msp_pkg::msp_reg_t r);
        return {r, 2'b00};
    endfunction

    task automatic apb_write(input paddr_t addr, input logic [msp_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apb_check(input paddr_t addr, input logic [msp_pkg::PDATA_W-1:0] want,
                             input int width);
        logic [msp_pkg::PDATA_W-1:0] mask;
        mask = '1;
        mask = mask >> (msp_pkg::PDATA_W - width);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if ((prdata & mask) !== (want & mask))
        begin
            $display("%0t: register at 0x%0h expected 0x%0h, got 0x%0h",
                     $time, addr, want & mask, prdata & mask);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_gains(input gain_set_t g);
        apb_write(reg_addr(msp_pkg::REG_GAIN_P), {{16{g.kp[15]}}, g.kp});
        apb_write(reg_addr(msp_pkg::REG_GAIN_I), {{16{g.ki[15]}}, g.ki});
        apb_write(reg_addr(msp_pkg::REG_GAIN_D), {{16{g.kd[15]}}, g.kd});
        apb_write(reg_addr(msp_pkg::REG_STEP_TIME), {17'd0, g.dt});
        apb_write(reg_addr(msp_pkg::REG_STEP_RATE), {17'd0, g.rate});
        // A write past the last register must leave every register alone.
        apb_write(paddr_t'((int'(msp_pkg::REG_STEP_RATE) + 1 + $urandom_range(0, 2)) * 4),
                  $urandom());
        apb_check(reg_addr(msp_pkg::REG_GAIN_P), {{16{g.kp[15]}}, g.kp}, 16);
        apb_check(reg_addr(msp_pkg::REG_GAIN_I), {{16{g.ki[15]}}, g.ki}, 16);
        apb_check(reg_addr(msp_pkg::REG_GAIN_D), {{16{g.kd[15]}}, g.kd}, 16);
        apb_check(reg_addr(msp_pkg::REG_STEP_TIME), {17'd0, g.dt}, 15);
        apb_check(reg_addr(msp_pkg::REG_STEP_RATE), {17'd0, g.rate}, 15);
        gains = g;
    endtask

    function automatic gain_set_t pick_gains(input int phase);
        gain_set_t g;
        case (phase % 5)
            0:
            begin
                g.kp   = msp_pkg::q_t'($urandom_range(0, 1024));
                g.ki   = msp_pkg::q_t'($urandom_range(0, 128));
                g.kd   = msp_pkg::q_t'($urandom_range(0, 256));
                g.dt   = 15'($urandom_range(1, 64));
                g.rate = 15'($urandom_range(256, 8192));
                if ($urandom_range(1) == 1)
                begin
                    g.ki = -g.ki;
                end
            end
            1:
            begin
                g.kp   = msp_pkg::Q_MAX;
                g.ki   = msp_pkg::Q_MAX;
                g.kd   = msp_pkg::Q_MAX;
                g.dt   = '1;
                g.rate = '1;
            end
            2:
            begin
                g.kp   = msp_pkg::Q_MIN;
                g.ki   = msp_pkg::Q_MIN;
                g.kd   = msp_pkg::Q_MIN;
                g.dt   = '0;
                g.rate = '0;
            end
            3:
            begin
                g.kp   = msp_pkg::q_t'($urandom());
                g.ki   = msp_pkg::q_t'($urandom());
                g.kd   = msp_pkg::q_t'($urandom());
                g.dt   = 15'($urandom());
                g.rate = 15'($urandom());
            end
            default:
            begin
                g = '0;
            end
        endcase
        return g;
    endfunction

    // Mostly updates near the set point, with wild speeds and the odd clear.
    function automatic cmd_row_t make_word();
        cmd_row_t w;
        int pick;
        w      = '0;
        pick   = $urandom_range(99);
        w.op   = msp_pkg::OPC_UPDATE;
        w.tgt  = 8'($urandom());
        w.meas = 8'($urandom());
        if (pick < 6)
        begin
            w.op = msp_pkg::OPC_CLEAR;
        end
        else if (pick < 55)
        begin
            w.meas = w.tgt + 8'($urandom_range(0, 16)) - 8'd8;
        end
        else if (pick >= 85)
        begin
            w.tgt  = $urandom_range(1) == 1 ? 8'd255 : 8'd0;
            w.meas = ~w.tgt;
        end
        return w;
    endfunction

    task automatic send_word(input cmd_row_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid          <= 1'b1;
        cmd.opcode         <= w.op;
        cmd.target_speed   <= w.tgt;
        cmd.measured_speed <= w.meas;
        do @(posedge clk); while (!cmd.ready);
        if (w.fixed)
        begin
            void'(next_power(w));
            power_due.push_back(w.want);
        end
        else
        begin
            power_due.push_back(next_power(w));
        end
        @(negedge clk);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (power_due.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        result.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (power_due.size() == 0)
                begin
                    $display("%0t: drive power expected none, got %0d", $time,
                             result.drive_power);
                    errors++;
                end
                else
                begin
                    due_power = power_due.pop_front();
                    if (result.drive_power !== due_power)
                    begin
                        $display("%0t: drive power expected %0d, got %0d", $time,
                                 due_power, result.drive_power);
                        errors++;
                    end
                end
            end
            if ((cmd.valid && cmd.ready) || (result.valid && result.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        clk                = 1'b0;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cmd.valid          = 1'b0;
        cmd.opcode         = msp_pkg::OPC_UPDATE;
        cmd.target_speed   = '0;
        cmd.measured_speed = '0;
        result.ready       = 1'b0;
        errors             = 0;
        quiet              = 0;
        send_idle_pct      = 19;
        recv_idle_pct      = 49;
        reset_model();

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The directed words run with the gains left at their reset values.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_word(DIRECTED[i]);
        end
        drain();

        n = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            program_gains(pick_gains(p));
            for (int k = 0; k < RANDOM_WORDS / PHASES; k++)
            begin
                if (n < RANDOM_WORDS / 3)
                begin
                    send_idle_pct = 19;
                    recv_idle_pct = 49;
                end
                else if (n < 2 * RANDOM_WORDS / 3)
                begin
                    send_idle_pct = 49;
                    recv_idle_pct = 19;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                send_word(make_word());
                n++;
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
